[rtl/core/portion_feed_motor_sequencer_macros.svh]
// Assertion macros for the portion feed motor sequencer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PORTION_FEED_MOTOR_SEQUENCER_MACROS_SVH
`define PORTION_FEED_MOTOR_SEQUENCER_MACROS_SVH

// same-cycle implication
`define PFMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/pfms_pkg.sv]
// Shared types and constants for the portion feed motor sequencer.
// No dependencies.
package pfms_pkg;

	localparam int PORTION_BITS = 8;
	localparam int TIMER_BITS   = 16;
	localparam int SETTLE_BITS  = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [TIMER_BITS-1:0]  SEEK_LIMIT     = 16'd200;
	localparam logic [TIMER_BITS-1:0]  JIGGLE_TICKS   = 16'd50;
	localparam logic [2:0]             LOW_NEEDED     = 3'd7;
	localparam logic [2:0]             JIGGLE_PHASES  = 3'd6;
	localparam logic [TIMER_BITS-1:0]  TIMEOUT_RESET  = 16'd500;
	localparam logic [SETTLE_BITS-1:0] SETTLE_RESET   = 10'd50;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE = 2'd2;

	localparam logic ERR_NONE    = 1'b0;
	localparam logic ERR_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK,
		PH_WAIT,
		PH_SETTLE,
		PH_JIGGLE
	} phase_t;

	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_FWD  = 2'd1,
		DRV_REV  = 2'd2
	} drive_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] portions;
		logic       sensor_level;
	} req_t;

	typedef struct packed {
		logic [1:0] motor_drive;
		logic       busy_res;
		logic       finished;
		logic [7:0] delivered;
		logic       error_code;
	} rsp_t;

	typedef struct packed {
		logic [TIMER_BITS-1:0]  portion_timeout;
		logic [SETTLE_BITS-1:0] settle_ticks;
		logic                   reverse_enable;
	} cfg_t;

endpackage

[rtl/core/portion_feed_motor_sequencer.sv]
// Portion feed motor sequencer: one request beat in, one result beat out per beat.
// Takes one request beat every clock while req_stall is low; a taken request passes the
// request register, then the result register, and its result waits there while rsp_stall holds.
// Depends on pfms_pkg and pfms_ctrl.

module portion_feed_motor_sequencer
	import pfms_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_t                     req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rsp_t                     rsp,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	req_t req_s1;
	logic req_valid_s1;
	rsp_t rsp_s2;
	logic rsp_valid_s2;
	cfg_t cfg_q;
	rsp_t rsp_next;
	logic go;

	assign go        = req_valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = req_valid_s1 && !go;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				req_valid_s1 <= 1'b1;
			else if (go)
				req_valid_s1 <= 1'b0;
			if (go)
				rsp_valid_s2 <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
		if (go)
			rsp_s2 <= rsp_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.portion_timeout <= TIMEOUT_RESET;
			cfg_q.settle_ticks    <= SETTLE_RESET;
			cfg_q.reverse_enable  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TIMEOUT: cfg_q.portion_timeout <= TIMER_BITS'(cfg_data);
				CFG_SETTLE:  cfg_q.settle_ticks    <= SETTLE_BITS'(cfg_data);
				CFG_REVERSE: cfg_q.reverse_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pfms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (req_s1),
		.cfg    (cfg_q),
		.rsp    (rsp_next)
	);

endmodule

[rtl/core/pfms_ctrl.sv]
// Sequencer state machine: state registers and per-item next-state logic.
// Depends on pfms_pkg and portion_feed_motor_sequencer_macros.svh.
`include "portion_feed_motor_sequencer_macros.svh"

module pfms_ctrl
	import pfms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  req_t req,
	input  cfg_t cfg,
	output rsp_t rsp
);

	phase_t                  phase_q, phase_d;
	logic [PORTION_BITS-1:0] remaining_q, remaining_d;
	logic [PORTION_BITS-1:0] done_q, done_d;
	logic [TIMER_BITS-1:0]   timer_q, timer_d;
	logic [2:0]              low_q, low_d;
	logic                    prev_q, prev_d;
	logic                    retried_q, retried_d;
	logic [2:0]              jstep_q, jstep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
			done_q      <= '0;
			timer_q     <= '0;
			low_q       <= '0;
			prev_q      <= 1'b1;
			retried_q   <= 1'b0;
			jstep_q     <= '0;
		end else if (go) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			done_q      <= done_d;
			timer_q     <= timer_d;
			low_q       <= low_d;
			prev_q      <= prev_d;
			retried_q   <= retried_d;
			jstep_q     <= jstep_d;
		end
	end

	always_comb begin
		logic [TIMER_BITS-1:0] tinc;
		logic                  pdone;
		logic                  tmo;
		logic                  fin;
		logic                  err;
		logic                  busy;
		drive_t                drv;

		phase_d     = phase_q;
		remaining_d = remaining_q;
		done_d      = done_q;
		timer_d     = timer_q;
		low_d       = low_q;
		prev_d      = prev_q;
		retried_d   = retried_q;
		jstep_d     = jstep_q;
		tinc        = timer_q + 1'b1;
		pdone       = 1'b0;
		tmo         = 1'b0;
		fin         = 1'b0;
		err         = ERR_NONE;
		busy        = (phase_q != PH_IDLE);

		if (req.kind == KIND_START) begin
			if (!busy) begin
				remaining_d = PORTION_BITS'(req.portions);
				done_d      = '0;
				retried_d   = 1'b0;
				jstep_d     = '0;
				prev_d      = 1'b1;
				timer_d     = '0;
				if (PORTION_BITS'(req.portions) == '0) begin
					phase_d = PH_IDLE;
					fin     = 1'b1;
				end else begin
					phase_d = PH_SEEK;
					low_d   = '0;
				end
			end
		end else begin
			case (phase_q)
				PH_SEEK: begin
					if (req.sensor_level) begin
						phase_d = PH_WAIT;
						timer_d = '0;
						low_d   = '0;
						prev_d  = 1'b1;
					end else begin
						timer_d = tinc;
						tmo     = (tinc >= SEEK_LIMIT);
					end
				end
				PH_WAIT: begin
					if (!req.sensor_level && !prev_q)
						low_d = low_q + 1'b1;
					prev_d = req.sensor_level;
					if (low_d >= LOW_NEEDED) begin
						low_d   = '0;
						phase_d = PH_SETTLE;
						timer_d = '0;
						pdone   = (cfg.settle_ticks == '0);
					end else begin
						timer_d = tinc;
						tmo     = (tinc >= cfg.portion_timeout) || (tinc == '0);
					end
				end
				PH_SETTLE: begin
					timer_d = tinc;
					pdone   = (tinc >= TIMER_BITS'(cfg.settle_ticks));
				end
				PH_JIGGLE: begin
					timer_d = tinc;
					if (tinc >= JIGGLE_TICKS) begin
						timer_d = '0;
						jstep_d = jstep_q + 1'b1;
						if (jstep_d >= JIGGLE_PHASES) begin
							jstep_d = '0;
							phase_d = PH_SEEK;
							low_d   = '0;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (pdone) begin
			done_d      = done_q + 1'b1;
			remaining_d = remaining_q - 1'b1;
			timer_d     = '0;
			if (remaining_d == '0) begin
				phase_d = PH_IDLE;
				fin     = 1'b1;
			end else begin
				phase_d = PH_SEEK;
				low_d   = '0;
			end
		end

		if (tmo) begin
			timer_d = '0;
			if (cfg.reverse_enable && !retried_q) begin
				retried_d = 1'b1;
				phase_d   = PH_JIGGLE;
				jstep_d   = '0;
			end else begin
				phase_d = PH_IDLE;
				fin     = 1'b1;
				err     = ERR_TIMEOUT;
			end
		end

		case (phase_d)
			PH_SEEK, PH_WAIT, PH_SETTLE: drv = DRV_FWD;
			PH_JIGGLE:                   drv = jstep_d[0] ? DRV_FWD : DRV_REV;
			default:                     drv = DRV_STOP;
		endcase

		rsp.motor_drive = drv;
		rsp.busy_res    = (phase_d != PH_IDLE);
		rsp.finished    = fin;
		rsp.delivered   = 8'(done_d);
		rsp.error_code  = fin ? err : ERR_NONE;
	end

	`PFMS_ASSERT_NOW(a_jiggle_retried, phase_q == PH_JIGGLE, retried_q, "jiggle without retry mark")
	`PFMS_ASSERT_NOW(a_jstep_range, 1'b1, jstep_q < JIGGLE_PHASES, "jiggle step out of range")
	`PFMS_ASSERT_NOW(a_low_range, 1'b1, low_q < LOW_NEEDED, "low count not cleared")
	`PFMS_ASSERT_NEXT(a_idle_tick, go && phase_q == PH_IDLE && req.kind == KIND_TICK, phase_q == PH_IDLE, "tick left idle")

endmodule
